// ----- hw/rtl/cvs_pkg.sv -----
package cvs_pkg;

	// Field widths.
	localparam int SP_W       = 13;
	localparam int STEP_W     = 10;
	localparam int CYC_W      = 8;
	localparam int PER_W      = 16;
	localparam int TIA_W      = 20;
	localparam int CNT_W      = 32;
	localparam int CUR_W      = 23;
	localparam int DAC_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_BEGIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLES = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TIA    = 3'd6;

	// Register reset values.
	localparam logic signed [SP_W-1:0] BEGIN_RST  = 13'sd0;
	localparam logic signed [SP_W-1:0] UPPER_RST  = 13'sd500;
	localparam logic signed [SP_W-1:0] LOWER_RST  = -13'sd500;
	localparam logic [STEP_W-1:0]      STEP_RST   = 10'd10;
	localparam logic [CYC_W-1:0]       CYCLES_RST = 8'd1;
	localparam logic [PER_W-1:0]       PERIOD_RST = 16'd100;
	localparam logic [TIA_W-1:0]       TIA_RST    = 20'd50000;

	// Target select codes.
	localparam logic [1:0] TGT_UPPER = 2'd0;
	localparam logic [1:0] TGT_LOWER = 2'd1;
	localparam logic [1:0] TGT_BEGIN = 2'd2;

	// DAC mapping: (setpoint + 4001) / 2, clamped to 0..4000.
	localparam logic signed [SP_W:0] DAC_OFFSET = 14'sd4001;
	localparam logic [SP_W-1:0]      DAC_MAX    = 13'd4000;

	// Current conversion.
	localparam int                QUO_W      = 23;
	localparam logic [29:0]       NANO_SCALE = 30'd1000000000;
	localparam logic [QUO_W:0]    CUR_LIMIT  = 24'd4000000;

	typedef logic signed [SP_W-1:0] mv_t;

	// Fields of one result as the sequencer sees them at the accepting edge.
	typedef struct packed {
		logic             sample_valid;
		logic [CNT_W-1:0] point_number;
		logic [CNT_W-1:0] time_ms;
		mv_t              setpoint_mv;
		logic             sweep_done;
	} seq_res_t;

endpackage

// ----- hw/rtl/cvs_seq.sv -----
module cvs_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step_en,
	input  logic                          kind,
	input  cvs_pkg::mv_t                  begin_mv,
	input  cvs_pkg::mv_t                  upper_vertex_mv,
	input  cvs_pkg::mv_t                  lower_vertex_mv,
	input  logic [cvs_pkg::STEP_W-1:0]    step_mv,
	input  logic [cvs_pkg::CYC_W-1:0]     cycle_total,
	input  logic [cvs_pkg::PER_W-1:0]     period_ms,
	output cvs_pkg::seq_res_t             res
);

	cvs_pkg::mv_t                 setpoint_q;
	logic [1:0]                   tsel_q;
	logic                         down_q;
	logic [cvs_pkg::CYC_W-1:0]    cyc_q;
	logic [cvs_pkg::CNT_W-1:0]    pt_q;
	logic [cvs_pkg::CNT_W-1:0]    tm_q;
	logic                         run_q;
	logic                         done_q;

	cvs_pkg::mv_t                 tgt;
	logic signed [cvs_pkg::SP_W:0] tgt_x;
	logic signed [cvs_pkg::SP_W:0] sp_dn;
	logic signed [cvs_pkg::SP_W:0] sp_up;
	cvs_pkg::mv_t                 sp_step;
	logic                         at_tgt;
	logic [cvs_pkg::CYC_W-1:0]    cyc_inc;
	logic                         last_cycle;

	// Current target of the sweep.
	always_comb begin
		unique case (tsel_q)
			cvs_pkg::TGT_UPPER: tgt = upper_vertex_mv;
			cvs_pkg::TGT_LOWER: tgt = lower_vertex_mv;
			default:            tgt = begin_mv;
		endcase
	end

	// One step toward the target, clamped at it.
	assign tgt_x   = {tgt[cvs_pkg::SP_W-1], tgt};
	assign sp_dn   = {setpoint_q[cvs_pkg::SP_W-1], setpoint_q}
		- $signed({4'd0, step_mv});
	assign sp_up   = {setpoint_q[cvs_pkg::SP_W-1], setpoint_q}
		+ $signed({4'd0, step_mv});
	assign at_tgt  = (setpoint_q == tgt);
	always_comb begin
		if (down_q) begin
			sp_step = (sp_dn < tgt_x) ? tgt : sp_dn[cvs_pkg::SP_W-1:0];
		end else begin
			sp_step = (sp_up > tgt_x) ? tgt : sp_up[cvs_pkg::SP_W-1:0];
		end
	end

	assign cyc_inc    = cyc_q + 1'b1;
	assign last_cycle = (cyc_inc >= cycle_total);

	// Result word fields for the item being accepted.
	always_comb begin
		res.sample_valid = kind & run_q;
		res.point_number = res.sample_valid ? pt_q : '0;
		res.time_ms      = res.sample_valid ? tm_q : '0;
		res.setpoint_mv  = kind ? setpoint_q : begin_mv;
		if (!kind) begin
			res.sweep_done = (cycle_total == '0);
		end else begin
			res.sweep_done = done_q
				| (run_q & at_tgt & (tsel_q == cvs_pkg::TGT_BEGIN) & last_cycle);
		end
	end

	// Sweep state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
			tsel_q     <= cvs_pkg::TGT_UPPER;
			down_q     <= 1'b0;
			cyc_q      <= '0;
			pt_q       <= 32'd1;
			tm_q       <= '0;
			run_q      <= 1'b0;
			done_q     <= 1'b0;
		end else if (step_en) begin
			if (!kind) begin
				setpoint_q <= begin_mv;
				tsel_q     <= cvs_pkg::TGT_UPPER;
				down_q     <= 1'b0;
				cyc_q      <= '0;
				pt_q       <= 32'd1;
				tm_q       <= '0;
				run_q      <= (cycle_total != '0);
				done_q     <= (cycle_total == '0);
			end else if (run_q) begin
				pt_q <= pt_q + 1'b1;
				tm_q <= tm_q + {16'd0, period_ms};
				if (at_tgt) begin
					unique case (tsel_q)
						cvs_pkg::TGT_UPPER: begin
							tsel_q <= cvs_pkg::TGT_LOWER;
							down_q <= 1'b1;
						end
						cvs_pkg::TGT_LOWER: begin
							tsel_q <= cvs_pkg::TGT_BEGIN;
							down_q <= 1'b0;
						end
						default: begin
							tsel_q <= cvs_pkg::TGT_UPPER;
							down_q <= 1'b0;
							cyc_q  <= cyc_inc;
							if (last_cycle) begin
								run_q  <= 1'b0;
								done_q <= 1'b1;
							end
						end
					endcase
				end else begin
					setpoint_q <= sp_step;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/cvs_cur.sv -----
module cvs_cur #(
	parameter int ADC_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [ADC_BITS-1:0]               code,
	input  logic [cvs_pkg::TIA_W-1:0]         tia_ohms,
	output logic                              done,
	output logic signed [cvs_pkg::CUR_W-1:0]  current_na
);

	localparam int QW    = cvs_pkg::QUO_W;
	localparam int MW    = ADC_BITS + 2;
	localparam int NUMW  = ADC_BITS + 4;
	localparam int NW    = MW + 30;
	localparam int DW    = ADC_BITS + cvs_pkg::TIA_W;
	localparam int CW    = $clog2(QW);
	localparam logic [ADC_BITS-1:0] FULL      = {ADC_BITS{1'b1}};
	localparam logic [NUMW-1:0]     FOUR_FULL = {2'b00, FULL, 2'b00};

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_ROUND = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]        st_q;
	logic [CW-1:0]     cnt_q;
	logic              done_q;
	logic              neg_q;
	logic              zero_q;
	logic [MW-1:0]     mag_q;
	logic [NW-1:0]     n_q;
	logic [DW-1:0]     den_q;
	logic [DW:0]       rem_q;
	logic [QW-1:0]     nlo_q;
	logic [QW-1:0]     q_q;
	logic [QW:0]       qr_q;
	logic signed [cvs_pkg::CUR_W-1:0] cur_q;

	logic [NUMW-1:0]   num;
	logic [NUMW-1:0]   num_abs;
	logic [DW:0]       n_hi;
	logic [DW:0]       trial;
	logic [DW:0]       trial_sub;
	logic              trial_ge;
	logic              round_up;
	logic [QW:0]       q_sat;

	// Signed numerator 8*code - 4*full scale, taken apart into sign and magnitude.
	assign num     = {1'b0, code, 3'b000} - FOUR_FULL;
	assign num_abs = num[NUMW-1] ? (~num + 1'b1) : num;

	// One restoring division step: shift in the next numerator bit.
	assign n_hi      = (DW+1)'(n_q[NW-1:QW]);
	assign trial     = {rem_q[DW-1:0], nlo_q[QW-1]};
	assign trial_ge  = (trial >= {1'b0, den_q});
	assign trial_sub = trial - {1'b0, den_q};
	assign round_up  = ({rem_q[DW-1:0], 1'b0} >= {1'b0, den_q});
	assign q_sat     = (qr_q > cvs_pkg::CUR_LIMIT) ? cvs_pkg::CUR_LIMIT : qr_q;

	// Sequencer of the serial divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						st_q <= ST_LOAD;
					end
				end
				ST_LOAD:  st_q <= ST_CHECK;
				ST_CHECK: begin
					if (zero_q || n_hi >= {1'b0, den_q}) begin
						st_q <= ST_FIN;
					end else begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						st_q <= ST_ROUND;
					end
				end
				ST_ROUND: st_q <= ST_FIN;
				ST_FIN: begin
					st_q   <= ST_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath of the serial divider.
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (start) begin
					neg_q  <= num[NUMW-1];
					mag_q  <= num_abs[MW-1:0];
					zero_q <= (num == '0);
				end
			end
			ST_LOAD: begin
				n_q   <= NW'(mag_q) * NW'(cvs_pkg::NANO_SCALE);
				den_q <= DW'(FULL) * DW'(tia_ohms);
			end
			ST_CHECK: begin
				rem_q <= n_hi;
				nlo_q <= n_q[QW-1:0];
				cnt_q <= CW'(QW - 1);
				if (zero_q) begin
					qr_q <= '0;
				end else begin
					qr_q <= '1;
				end
			end
			ST_DIV: begin
				rem_q <= trial_ge ? trial_sub : trial;
				q_q   <= {q_q[QW-2:0], trial_ge};
				nlo_q <= {nlo_q[QW-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			ST_ROUND: qr_q <= {1'b0, q_q} + (QW+1)'(round_up);
			ST_FIN: begin
				if (neg_q) begin
					cur_q <= $signed(~q_sat[cvs_pkg::CUR_W-1:0] + 1'b1);
				end else begin
					cur_q <= $signed(q_sat[cvs_pkg::CUR_W-1:0]);
				end
			end
			default: ;
		endcase
	end

	assign done       = done_q;
	assign current_na = cur_q;

endmodule

// ----- hw/rtl/cyclic_voltammetry_sweep.sv -----
// Cyclic-voltammetry triangle-sweep sequencer.
// Input channel (in_valid / in_stall): kind 0 starts a sweep at the begin
// potential, kind 1 is a sample tick carrying the current ADC code.
// Output channel (out_valid / out_stall): one result word per input word,
// with point number, time, applied setpoint, current in nA, DAC voltage
// and the done flag.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while no word is in flight.
// A tick during a running sweep converts the current with a bit-serial
// restoring divider (one quotient bit per cycle, 23 bits plus load, range
// check and rounding): the result is loaded once the divider is done and
// the output is free, and the next input word can be taken in the cycle
// after that load. A tick whose current is zero or whose quotient overflows
// 23 bits skips the divide, as do start words and ticks outside a sweep.
// The output register parts the two sides: a new input word is taken while
// the previous result still waits under out_stall; a second result waits
// inside the block and holds in_stall high until the output frees up.
// Reset clears the sweep state to idle and loads the register defaults.
module cyclic_voltammetry_sweep #(
	parameter int ADC_BITS = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  kind,
	input  logic [ADC_BITS-1:0]                   current_code,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  sample_valid,
	output logic [cvs_pkg::CNT_W-1:0]             point_number,
	output logic [cvs_pkg::CNT_W-1:0]             time_ms,
	output logic signed [cvs_pkg::SP_W-1:0]       setpoint_mv,
	output logic signed [cvs_pkg::CUR_W-1:0]      current_na,
	output logic [cvs_pkg::DAC_W-1:0]             dac_mv,
	output logic                                  sweep_done,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cvs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [cvs_pkg::CFG_DATA_W-1:0]        cfg_data
);

	cvs_pkg::mv_t                  begin_q;
	cvs_pkg::mv_t                  upper_q;
	cvs_pkg::mv_t                  lower_q;
	logic [cvs_pkg::STEP_W-1:0]    step_q;
	logic [cvs_pkg::CYC_W-1:0]     cycles_q;
	logic [cvs_pkg::PER_W-1:0]     period_q;
	logic [cvs_pkg::TIA_W-1:0]     tia_q;

	logic                          pend_q;
	logic                          wait_q;
	cvs_pkg::seq_res_t             res_q;
	cvs_pkg::seq_res_t             seq_res;

	logic                          out_valid_q;
	logic                          sample_valid_q;
	logic [cvs_pkg::CNT_W-1:0]     point_q;
	logic [cvs_pkg::CNT_W-1:0]     time_q;
	cvs_pkg::mv_t                  setpoint_q;
	logic signed [cvs_pkg::CUR_W-1:0] current_q;
	logic [cvs_pkg::DAC_W-1:0]     dac_q;
	logic                          done_q;

	logic                          in_acc;
	logic                          cur_start;
	logic                          cur_done;
	logic signed [cvs_pkg::CUR_W-1:0] cur_value;
	logic                          res_ready;
	logic                          out_free;
	logic                          out_load;
	logic signed [cvs_pkg::SP_W:0] dac_sum;
	logic [cvs_pkg::SP_W-1:0]      dac_half;
	logic [cvs_pkg::DAC_W-1:0]     dac_val;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_q  <= cvs_pkg::BEGIN_RST;
			upper_q  <= cvs_pkg::UPPER_RST;
			lower_q  <= cvs_pkg::LOWER_RST;
			step_q   <= cvs_pkg::STEP_RST;
			cycles_q <= cvs_pkg::CYCLES_RST;
			period_q <= cvs_pkg::PERIOD_RST;
			tia_q    <= cvs_pkg::TIA_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cvs_pkg::REG_BEGIN:  begin_q  <= $signed(cfg_data[cvs_pkg::SP_W-1:0]);
				cvs_pkg::REG_UPPER:  upper_q  <= $signed(cfg_data[cvs_pkg::SP_W-1:0]);
				cvs_pkg::REG_LOWER:  lower_q  <= $signed(cfg_data[cvs_pkg::SP_W-1:0]);
				cvs_pkg::REG_STEP:   step_q   <= cfg_data[cvs_pkg::STEP_W-1:0];
				cvs_pkg::REG_CYCLES: cycles_q <= cfg_data[cvs_pkg::CYC_W-1:0];
				cvs_pkg::REG_PERIOD: period_q <= cfg_data[cvs_pkg::PER_W-1:0];
				cvs_pkg::REG_TIA:    tia_q    <= cfg_data[cvs_pkg::TIA_W-1:0];
				default: ;
			endcase
		end
	end

	// Input handshake: one word in flight inside the block at a time.
	assign in_stall  = pend_q;
	assign in_acc    = in_valid & ~in_stall;
	assign cur_start = in_acc & seq_res.sample_valid;

	cvs_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.step_en         (in_acc),
		.kind            (kind),
		.begin_mv        (begin_q),
		.upper_vertex_mv (upper_q),
		.lower_vertex_mv (lower_q),
		.step_mv         (step_q),
		.cycle_total     (cycles_q),
		.period_ms       (period_q),
		.res             (seq_res)
	);

	cvs_cur #(
		.ADC_BITS (ADC_BITS)
	) u_cur (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cur_start),
		.code       (current_code),
		.tia_ohms   (tia_q),
		.done       (cur_done),
		.current_na (cur_value)
	);

	// Pending result: sequencer fields wait here for the current conversion.
	assign res_ready = pend_q & (~wait_q | cur_done);
	assign out_free  = ~out_valid_q | ~out_stall;
	assign out_load  = res_ready & out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			wait_q <= 1'b0;
		end else begin
			if (in_acc) begin
				pend_q <= 1'b1;
				wait_q <= seq_res.sample_valid;
			end else begin
				if (cur_done) begin
					wait_q <= 1'b0;
				end
				if (out_load) begin
					pend_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= seq_res;
		end
	end

	// DAC voltage: (setpoint + 4001) / 2, clamped to 0..4000.
	assign dac_sum  = {res_q.setpoint_mv[cvs_pkg::SP_W-1], res_q.setpoint_mv}
		+ cvs_pkg::DAC_OFFSET;
	assign dac_half = dac_sum[cvs_pkg::SP_W:1];
	always_comb begin
		if (dac_sum[cvs_pkg::SP_W]) begin
			dac_val = '0;
		end else if (dac_half > cvs_pkg::DAC_MAX) begin
			dac_val = cvs_pkg::DAC_MAX[cvs_pkg::DAC_W-1:0];
		end else begin
			dac_val = dac_half[cvs_pkg::DAC_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_valid_q <= res_q.sample_valid;
			point_q        <= res_q.point_number;
			time_q         <= res_q.time_ms;
			setpoint_q     <= res_q.setpoint_mv;
			current_q      <= res_q.sample_valid ? cur_value : '0;
			dac_q          <= dac_val;
			done_q         <= res_q.sweep_done;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_valid = sample_valid_q;
	assign point_number = point_q;
	assign time_ms      = time_q;
	assign setpoint_mv  = setpoint_q;
	assign current_na   = current_q;
	assign dac_mv       = dac_q;
	assign sweep_done   = done_q;

	// A taken word always leaves a pending result behind it.
	a_acc_pend: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> pend_q)
		else $error("accepted word left no pending result");

	// The divider finishes only for a conversion that is being waited on.
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cur_done |-> (pend_q && wait_q))
		else $error("current conversion finished with nobody waiting");

	// A conversion never starts on top of one in progress.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cur_start |-> !wait_q)
		else $error("current conversion started while busy");

	// The DAC code stays inside its range.
	a_dac_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (dac_mv <= 12'd4000))
		else $error("DAC voltage out of range");

endmodule
